FILE: src/c8x_pkg.sv
// Shared types and constants for the CHIP-8 execute core.
package c8x_pkg;

	localparam int PC_W   = 12;
	localparam int REG_W  = 8;
	localparam int IDX_W  = 4;
	localparam int I_W    = 16;
	localparam int NREGS  = 16;

	localparam logic [PC_W-1:0]  PC_RESET = 12'h200;
	localparam logic [IDX_W-1:0] FLAG_IDX = 4'hF;
	localparam logic [IDX_W-1:0] V0_IDX   = 4'h0;

	localparam logic STATUS_OK          = 1'b0;
	localparam logic STATUS_UNSUPPORTED = 1'b1;

	// top nibble of the opcode word
	typedef enum logic [3:0] {
		OP_SYS     = 4'h0,
		OP_JP      = 4'h1,
		OP_CALL    = 4'h2,
		OP_SE_IMM  = 4'h3,
		OP_SNE_IMM = 4'h4,
		OP_SE_REG  = 4'h5,
		OP_LD_IMM  = 4'h6,
		OP_ADD_IMM = 4'h7,
		OP_ALU     = 4'h8,
		OP_SNE_REG = 4'h9,
		OP_LD_I    = 4'hA,
		OP_JP_V0   = 4'hB,
		OP_RND     = 4'hC,
		OP_DRW     = 4'hD,
		OP_SKP     = 4'hE,
		OP_MISC    = 4'hF
	} opcode_t;

	// 8XYn sub-operations
	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	// FXkk sub-operations handled here
	localparam logic [7:0] MISC_LD_VX_DT = 8'h07;
	localparam logic [7:0] MISC_LD_DT_VX = 8'h15;
	localparam logic [7:0] MISC_LD_ST_VX = 8'h18;
	localparam logic [7:0] MISC_ADD_I_VX = 8'h1E;

	// register file write request
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [REG_W-1:0] data;
	} rf_wr_t;

	// machine state seen by the execute logic
	typedef struct packed {
		logic [PC_W-1:0]  pc;
		logic [I_W-1:0]   i;
		logic [REG_W-1:0] dt;
		logic [REG_W-1:0] st;
		logic [REG_W-1:0] vf;
	} mach_state_t;

	// execute outcome: next state plus reporting fields
	typedef struct packed {
		mach_state_t      nxt;
		logic             status;
		logic             dest_written;
		logic [IDX_W-1:0] dest_index;
		logic [REG_W-1:0] dest_value;
		rf_wr_t           rf_wr;
	} exec_res_t;

endpackage

FILE: src/c8x_regfile.sv
// V0..VF storage: synchronous 16x8 memory, two registered read ports, one write port.
module c8x_regfile (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [c8x_pkg::IDX_W-1:0]       rd_addr_a,
	input  logic [c8x_pkg::IDX_W-1:0]       rd_addr_b,
	output logic [c8x_pkg::REG_W-1:0]       rd_data_a,
	output logic [c8x_pkg::REG_W-1:0]       rd_data_b,
	input  c8x_pkg::rf_wr_t                 wr
);

	logic [c8x_pkg::REG_W-1:0] mem [c8x_pkg::NREGS];
	logic [c8x_pkg::NREGS-1:0] valid_q;
	logic [c8x_pkg::REG_W-1:0] rd_a_q;
	logic [c8x_pkg::REG_W-1:0] rd_b_q;

	// entries read as zero until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// read-before-write: a same-edge write is not visible here
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= valid_q[rd_addr_a] ? mem[rd_addr_a] : '0;
			rd_b_q <= valid_q[rd_addr_b] ? mem[rd_addr_b] : '0;
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

FILE: src/c8x_exec.sv
// Instruction decode and execute: operands and state in, next state and result out.
module c8x_exec (
	input  logic [15:0]                 instruction,
	input  logic [c8x_pkg::REG_W-1:0]   random_byte,
	input  logic [c8x_pkg::REG_W-1:0]   vx,
	input  logic [c8x_pkg::REG_W-1:0]   vy,     // V0 for BNNN
	input  c8x_pkg::mach_state_t        cur,
	output c8x_pkg::exec_res_t          res
);

	logic [c8x_pkg::IDX_W-1:0] x;
	logic [3:0]                n;
	logic [7:0]                kk;
	logic [c8x_pkg::PC_W-1:0]  nnn;
	logic [c8x_pkg::PC_W-1:0]  pc_next;
	logic [c8x_pkg::PC_W-1:0]  pc_skip;
	logic [c8x_pkg::REG_W:0]   sum;

	assign x       = instruction[11:8];
	assign n       = instruction[3:0];
	assign kk      = instruction[7:0];
	assign nnn     = instruction[11:0];
	assign pc_next = cur.pc + 12'd2;
	assign pc_skip = cur.pc + 12'd4;
	assign sum     = {1'b0, vx} + {1'b0, vy};

	always_comb begin
		logic                      bad;
		logic                      wr;
		logic                      wflag;
		logic [c8x_pkg::REG_W-1:0] val;
		logic [c8x_pkg::REG_W-1:0] flag;
		logic [c8x_pkg::PC_W-1:0]  npc;
		c8x_pkg::mach_state_t      nxt;

		bad   = 1'b0;
		wr    = 1'b0;
		wflag = 1'b0;
		val   = '0;
		flag  = '0;
		npc   = pc_next;
		nxt   = cur;

		case (c8x_pkg::opcode_t'(instruction[15:12]))
			c8x_pkg::OP_JP: begin
				npc = nnn;
			end
			c8x_pkg::OP_SE_IMM: begin
				if (vx == kk) npc = pc_skip;
			end
			c8x_pkg::OP_SNE_IMM: begin
				if (vx != kk) npc = pc_skip;
			end
			c8x_pkg::OP_SE_REG: begin
				if (n != 4'h0) bad = 1'b1;
				else if (vx == vy) npc = pc_skip;
			end
			c8x_pkg::OP_SNE_REG: begin
				if (n != 4'h0) bad = 1'b1;
				else if (vx != vy) npc = pc_skip;
			end
			c8x_pkg::OP_LD_IMM: begin
				wr  = 1'b1;
				val = kk;
			end
			c8x_pkg::OP_ADD_IMM: begin
				wr  = 1'b1;
				val = vx + kk;
			end
			c8x_pkg::OP_ALU: begin
				wr = 1'b1;
				case (n)
					c8x_pkg::ALU_MOV: val = vy;
					c8x_pkg::ALU_OR:  val = vx | vy;
					c8x_pkg::ALU_AND: val = vx & vy;
					c8x_pkg::ALU_XOR: val = vx ^ vy;
					c8x_pkg::ALU_ADD: begin
						val   = sum[c8x_pkg::REG_W-1:0];
						flag  = {7'd0, sum[c8x_pkg::REG_W]};
						wflag = 1'b1;
					end
					c8x_pkg::ALU_SUB: begin
						val   = vx - vy;
						flag  = {7'd0, (vx >= vy)};
						wflag = 1'b1;
					end
					c8x_pkg::ALU_SHR: begin
						val   = {1'b0, vx[7:1]};
						flag  = {7'd0, vx[0]};
						wflag = 1'b1;
					end
					c8x_pkg::ALU_SUBN: begin
						val   = vy - vx;
						flag  = {7'd0, (vy >= vx)};
						wflag = 1'b1;
					end
					c8x_pkg::ALU_SHL: begin
						val   = {vx[6:0], 1'b0};
						flag  = {7'd0, vx[7]};
						wflag = 1'b1;
					end
					default: begin
						bad = 1'b1;
						wr  = 1'b0;
					end
				endcase
			end
			c8x_pkg::OP_LD_I: begin
				nxt.i = {4'd0, nnn};
			end
			c8x_pkg::OP_JP_V0: begin
				npc = nnn + {4'd0, vy};
			end
			c8x_pkg::OP_RND: begin
				wr  = 1'b1;
				val = random_byte & kk;
			end
			c8x_pkg::OP_MISC: begin
				case (kk)
					c8x_pkg::MISC_LD_VX_DT: begin
						wr  = 1'b1;
						val = cur.dt;
					end
					c8x_pkg::MISC_LD_DT_VX: nxt.dt = vx;
					c8x_pkg::MISC_LD_ST_VX: nxt.st = vx;
					c8x_pkg::MISC_ADD_I_VX: nxt.i  = cur.i + {8'd0, vx};
					default:                bad    = 1'b1;
				endcase
			end
			default: begin
				bad = 1'b1;
			end
		endcase

		// flag write lands after the Vx write, so it wins on VF
		if (wr && x == c8x_pkg::FLAG_IDX) nxt.vf = val;
		if (wflag) nxt.vf = flag;
		nxt.pc = npc;

		if (bad) begin
			res.nxt          = cur;
			res.status       = c8x_pkg::STATUS_UNSUPPORTED;
			res.dest_written = 1'b0;
			res.dest_index   = '0;
			res.dest_value   = '0;
			res.rf_wr        = '0;
		end else begin
			res.nxt          = nxt;
			res.status       = c8x_pkg::STATUS_OK;
			res.dest_written = wr;
			res.dest_index   = wr ? x : '0;
			res.dest_value   = wr ? ((x == c8x_pkg::FLAG_IDX) ? nxt.vf : val) : '0;
			res.rf_wr.en     = wr && (x != c8x_pkg::FLAG_IDX);
			res.rf_wr.addr   = x;
			res.rf_wr.data   = val;
		end
	end

endmodule

FILE: src/chip8_instruction_execute_core.sv
// CHIP-8 execute core top level: operand read stage, execute/writeback stage, output register.
//
//  channel | dir | signals                        | transaction
//  --------+-----+--------------------------------+-----------------------------------------
//  s_*     | in  | s_tvalid s_tready s_tdata[23:0]| one opcode word plus random byte
//  m_*     | out | m_tvalid m_tready m_tdata[71:0]| one execute result; tuser = status
//          |     | m_tuser[0]                     |
//
// The register file is a synchronous memory read at accept, and execute plus writeback
// happen in the following stage, where the output register is loaded; one instruction per
// cycle sustained while m_tready is held high.
// A write from the previous instruction is forwarded to the next one's operands.
// VF, pc, I and the timers live in flip-flops and are updated at writeback.
// Reset: asynchronous, clears state to pc 0x200 and everything else zero; no clearing pass.
// Stalls: m_tready low holds the result; the execute stage then holds, and s_tready drops
// only when both the execute stage and the output register are occupied.
module chip8_instruction_execute_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] instruction, [23:16] random_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [11:0] next_pc, [12] dest_written, [16:13] dest_index,
	                               // [24:17] dest_value, [32:25] flag_value,
	                               // [48:33] index_value, [56:49] delay_value,
	                               // [64:57] sound_value, [71:65] zero
	output logic [0:0]  m_tuser    // [0] status
);

	logic                            s_fire;
	logic                            s1_fire;
	logic                            out_free;

	// stage 1: operands coming out of the register file
	logic                            s1_valid_q;
	logic [15:0]                     instr_s1;
	logic [c8x_pkg::REG_W-1:0]       rnd_s1;

	// architectural state kept in flops
	c8x_pkg::mach_state_t            state_q;

	// last register file write, for operand bypass
	logic                            fwd_valid_q;
	logic [c8x_pkg::IDX_W-1:0]       fwd_idx_q;
	logic [c8x_pkg::REG_W-1:0]       fwd_data_q;

	logic [c8x_pkg::IDX_W-1:0]       rd_addr_b;
	logic [c8x_pkg::REG_W-1:0]       rd_data_a;
	logic [c8x_pkg::REG_W-1:0]       rd_data_b;
	logic [c8x_pkg::IDX_W-1:0]       x_s1;
	logic [c8x_pkg::IDX_W-1:0]       b_idx_s1;
	logic [c8x_pkg::REG_W-1:0]       vx_s1;
	logic [c8x_pkg::REG_W-1:0]       vb_s1;
	c8x_pkg::exec_res_t              res_s1;
	c8x_pkg::rf_wr_t                 rf_wr;

	// output register
	logic                            m_valid_q;
	logic [71:0]                     m_data_q;
	logic                            m_user_q;

	assign out_free = !m_valid_q || m_tready;
	assign s1_fire  = s1_valid_q && out_free;
	assign s_tready = !s1_valid_q || out_free;
	assign s_fire   = s_tvalid && s_tready;

	// BNNN needs V0 rather than Vy; port B serves both
	assign rd_addr_b = (c8x_pkg::opcode_t'(s_tdata[15:12]) == c8x_pkg::OP_JP_V0) ?
	                   c8x_pkg::V0_IDX : s_tdata[7:4];

	assign rf_wr.en   = s1_fire && res_s1.rf_wr.en;
	assign rf_wr.addr = res_s1.rf_wr.addr;
	assign rf_wr.data = res_s1.rf_wr.data;

	c8x_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (s_fire),
		.rd_addr_a (s_tdata[11:8]),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.wr        (rf_wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			instr_s1 <= s_tdata[15:0];
			rnd_s1   <= s_tdata[23:16];
		end
	end

	// operand select: VF from its flop, otherwise bypass the last write over memory data
	assign x_s1     = instr_s1[11:8];
	assign b_idx_s1 = (c8x_pkg::opcode_t'(instr_s1[15:12]) == c8x_pkg::OP_JP_V0) ?
	                  c8x_pkg::V0_IDX : instr_s1[7:4];

	always_comb begin
		if (x_s1 == c8x_pkg::FLAG_IDX) vx_s1 = state_q.vf;
		else if (fwd_valid_q && fwd_idx_q == x_s1) vx_s1 = fwd_data_q;
		else vx_s1 = rd_data_a;

		if (b_idx_s1 == c8x_pkg::FLAG_IDX) vb_s1 = state_q.vf;
		else if (fwd_valid_q && fwd_idx_q == b_idx_s1) vb_s1 = fwd_data_q;
		else vb_s1 = rd_data_b;
	end

	c8x_exec u_exec (
		.instruction (instr_s1),
		.random_byte (rnd_s1),
		.vx          (vx_s1),
		.vy          (vb_s1),
		.cur         (state_q),
		.res         (res_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.pc  <= c8x_pkg::PC_RESET;
			state_q.i   <= '0;
			state_q.dt  <= '0;
			state_q.st  <= '0;
			state_q.vf  <= '0;
			fwd_valid_q <= 1'b0;
			fwd_idx_q   <= '0;
			fwd_data_q  <= '0;
		end else if (s1_fire) begin
			state_q <= res_s1.nxt;
			if (res_s1.rf_wr.en) begin
				fwd_valid_q <= 1'b1;
				fwd_idx_q   <= res_s1.rf_wr.addr;
				fwd_data_q  <= res_s1.rf_wr.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			m_data_q <= {7'd0,
			             res_s1.nxt.st,
			             res_s1.nxt.dt,
			             res_s1.nxt.i,
			             res_s1.nxt.vf,
			             res_s1.dest_value,
			             res_s1.dest_index,
			             res_s1.dest_written,
			             res_s1.nxt.pc};
			m_user_q <= res_s1.status;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_user_q;

endmodule

FILE: src/c8x_checker.sv
// Port-level checks for the CHIP-8 execute core, bound to the top level.
module c8x_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// unsupported instructions write no register
	a_unsup_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] == c8x_pkg::STATUS_UNSUPPORTED |-> m_tdata[12] == 1'b0)
		else $error("unsupported instruction reported a register write");

	// no write means zero destination fields
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[12] |-> m_tdata[16:13] == 4'h0 && m_tdata[24:17] == 8'h00)
		else $error("destination fields set without a write");

	// a write to VF shows the same value as the flag field
	a_vf_dest: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12] && m_tdata[16:13] == c8x_pkg::FLAG_IDX
		|-> m_tdata[24:17] == m_tdata[32:25])
		else $error("VF destination value differs from flag value");

endmodule

bind chip8_instruction_execute_core c8x_checker u_c8x_checker (.*);

FILE: dv/chip8_exec_checker.sv
// Checker for the CHIP-8 execute core: tracks machine state, predicts each result, compares.
module chip8_exec_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,
	input  logic [0:0]  m_tuser,
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [c8x_pkg::PC_W-1:0]  next_pc;
		logic                      status;
		logic                      dest_written;
		logic [c8x_pkg::IDX_W-1:0] dest_index;
		logic [c8x_pkg::REG_W-1:0] dest_value;
		logic [c8x_pkg::REG_W-1:0] flag_value;
		logic [c8x_pkg::I_W-1:0]   index_value;
		logic [c8x_pkg::REG_W-1:0] delay_value;
		logic [c8x_pkg::REG_W-1:0] sound_value;
	} exec_out_t;

	logic [c8x_pkg::REG_W-1:0] vregs [c8x_pkg::NREGS];
	logic [c8x_pkg::I_W-1:0]   ireg;
	logic [c8x_pkg::PC_W-1:0]  pc_q;
	logic [c8x_pkg::REG_W-1:0] dt_q;
	logic [c8x_pkg::REG_W-1:0] st_q;

	exec_out_t expected_results[$];
	int        mismatch_cnt = 0;

	task automatic reset_machine();
		foreach (vregs[k]) vregs[k] = '0;
		ireg = '0;
		pc_q = c8x_pkg::PC_RESET;
		dt_q = '0;
		st_q = '0;
	endtask

	// executes one opcode word against the tracked state and returns what the core should report
	function automatic exec_out_t exec_instr(logic [15:0] word, logic [7:0] rnd);
		c8x_pkg::opcode_t          op;
		logic [3:0]                x, y, n;
		logic [7:0]                kk, vx, vy, val, flag;
		logic [c8x_pkg::PC_W-1:0]  nnn, pc_now, npc, skip_pc;
		logic [8:0]                sum;
		logic                      bad, wr, wflag;
		exec_out_t                 r;
		op      = c8x_pkg::opcode_t'(word[15:12]);
		x       = word[11:8];
		y       = word[7:4];
		n       = word[3:0];
		kk      = word[7:0];
		nnn     = word[11:0];
		pc_now  = pc_q;
		npc     = pc_now + 12'd2;
		skip_pc = pc_now + 12'd4;
		vx      = vregs[x];
		vy      = vregs[y];
		bad     = 1'b0;
		wr      = 1'b0;
		wflag   = 1'b0;
		val     = '0;
		flag    = '0;
		case (op)
			c8x_pkg::OP_JP: npc = nnn;
			c8x_pkg::OP_SE_IMM: if (vx == kk) npc = skip_pc;
			c8x_pkg::OP_SNE_IMM: if (vx != kk) npc = skip_pc;
			c8x_pkg::OP_SE_REG: begin
				if (n != 4'h0) bad = 1'b1;
				else if (vx == vy) npc = skip_pc;
			end
			c8x_pkg::OP_LD_IMM: begin
				wr  = 1'b1;
				val = kk;
			end
			c8x_pkg::OP_ADD_IMM: begin
				wr  = 1'b1;
				val = vx + kk;
			end
			c8x_pkg::OP_ALU: begin
				wr = 1'b1;
				case (n)
					c8x_pkg::ALU_MOV: val = vy;
					c8x_pkg::ALU_OR:  val = vx | vy;
					c8x_pkg::ALU_AND: val = vx & vy;
					c8x_pkg::ALU_XOR: val = vx ^ vy;
					c8x_pkg::ALU_ADD: begin
						sum   = {1'b0, vx} + {1'b0, vy};
						val   = sum[7:0];
						flag  = {7'd0, sum[8]};
						wflag = 1'b1;
					end
					c8x_pkg::ALU_SUB: begin
						val   = vx - vy;
						flag  = {7'd0, vx >= vy};
						wflag = 1'b1;
					end
					c8x_pkg::ALU_SHR: begin
						val   = vx >> 1;
						flag  = {7'd0, vx[0]};
						wflag = 1'b1;
					end
					c8x_pkg::ALU_SUBN: begin
						val   = vy - vx;
						flag  = {7'd0, vy >= vx};
						wflag = 1'b1;
					end
					c8x_pkg::ALU_SHL: begin
						val   = vx << 1;
						flag  = {7'd0, vx[7]};
						wflag = 1'b1;
					end
					default: begin
						bad = 1'b1;
						wr  = 1'b0;
					end
				endcase
			end
			c8x_pkg::OP_SNE_REG: begin
				if (n != 4'h0) bad = 1'b1;
				else if (vx != vy) npc = skip_pc;
			end
			c8x_pkg::OP_LD_I: ireg = {4'd0, nnn};
			c8x_pkg::OP_JP_V0: npc = nnn + {4'd0, vregs[c8x_pkg::V0_IDX]};
			c8x_pkg::OP_RND: begin
				wr  = 1'b1;
				val = rnd & kk;
			end
			c8x_pkg::OP_MISC: begin
				case (kk)
					c8x_pkg::MISC_LD_VX_DT: begin
						wr  = 1'b1;
						val = dt_q;
					end
					c8x_pkg::MISC_LD_DT_VX: dt_q = vx;
					c8x_pkg::MISC_LD_ST_VX: st_q = vx;
					c8x_pkg::MISC_ADD_I_VX: ireg = ireg + {8'd0, vx};
					default: bad = 1'b1;
				endcase
			end
			default: bad = 1'b1;
		endcase
		if (bad) begin
			npc = pc_now;
			wr  = 1'b0;
		end else begin
			if (wr) vregs[x] = val;
			// flag written after the destination, so VF as target keeps the flag
			if (wflag) vregs[c8x_pkg::FLAG_IDX] = flag;
			pc_q = npc;
		end
		r.next_pc      = npc;
		r.status       = bad ? c8x_pkg::STATUS_UNSUPPORTED : c8x_pkg::STATUS_OK;
		r.dest_written = wr;
		r.dest_index   = wr ? x : '0;
		r.dest_value   = wr ? vregs[x] : '0;
		r.flag_value   = vregs[c8x_pkg::FLAG_IDX];
		r.index_value  = ireg;
		r.delay_value  = dt_q;
		r.sound_value  = st_q;
		return r;
	endfunction

	task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		exec_out_t got, want;
		if (!arst_n) begin
			reset_machine();
			expected_results.delete();
			pending <= 0;
		end else begin
			// result side first: an input accepted on this edge cannot be answered on it
			if (m_tvalid && m_tready) begin
				got.next_pc      = m_tdata[11:0];
				got.dest_written = m_tdata[12];
				got.dest_index   = m_tdata[16:13];
				got.dest_value   = m_tdata[24:17];
				got.flag_value   = m_tdata[32:25];
				got.index_value  = m_tdata[48:33];
				got.delay_value  = m_tdata[56:49];
				got.sound_value  = m_tdata[64:57];
				got.status       = m_tuser[0];
				if (expected_results.size() == 0) begin
					$error("result transaction with no instruction outstanding");
					mismatch_cnt++;
				end else begin
					want = expected_results.pop_front();
					cmp_field("next_pc", 16'(want.next_pc), 16'(got.next_pc));
					cmp_field("status", 16'(want.status), 16'(got.status));
					cmp_field("dest_written", 16'(want.dest_written),
					          16'(got.dest_written));
					cmp_field("dest_index", 16'(want.dest_index), 16'(got.dest_index));
					cmp_field("dest_value", 16'(want.dest_value), 16'(got.dest_value));
					cmp_field("flag_value", 16'(want.flag_value), 16'(got.flag_value));
					cmp_field("index_value", want.index_value, got.index_value);
					cmp_field("delay_value", 16'(want.delay_value), 16'(got.delay_value));
					cmp_field("sound_value", 16'(want.sound_value), 16'(got.sound_value));
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(exec_instr(s_tdata[15:0], s_tdata[23:16]));
			pending    <= expected_results.size();
			mismatches <= mismatch_cnt;
		end
	end

endmodule

FILE: dv/tb.sv
// Top-level testbench for the CHIP-8 execute core: clock, reset, stimulus, back-pressure, verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM      = 850;
	localparam int HOLD_AT       = 300;  // instruction count that triggers the long receiver stall
	localparam int HOLD_CYCLES   = 150;
	localparam int DRAIN_AT      = 500;  // sender drains the core completely here
	localparam int STALL_LIMIT   = 1000; // cycles with no transaction on either channel

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [15:0] instruction, [23:16] random_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // [11:0] next_pc .. [64:57] sound_value, see core header
	logic [0:0]  m_tuser;   // [0] status

	int mismatches;
	int pending;
	int sent_cnt  = 0;
	int idle_cyc  = 0;

	logic [23:0] directed_q[$];

	always #10 clk = ~clk;

	chip8_instruction_execute_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	chip8_exec_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Watchdog: any transaction on either side resets the count.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cyc <= 0;
		end else if (idle_cyc >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cyc <= idle_cyc + 1;
		end
	end

	// Receiver: stretches of ready patterns (some fully open), plus one long hold-off
	// once enough instructions have gone in, so the core fills and drops s_tready.
	initial begin
		int   run_len;
		logic [7:0] mask;
		bit   hold_done;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		@(posedge arst_n);
		forever begin
			run_len = $urandom_range(10, 60);
			mask    = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
			for (int k = 0; k < run_len; k++) begin
				m_tready <= mask[k % 8];
				@(posedge clk);
				if (!hold_done && sent_cnt >= HOLD_AT) begin
					hold_done = 1'b1;
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
			end
		end
	end

	// one instruction transaction; valid is left high for the caller to drop or reuse
	task automatic send_instr(logic [15:0] word, logic [7:0] rnd);
		s_tvalid <= 1'b1;
		s_tdata  <= {rnd, word};
		do @(posedge clk); while (!s_tready);
		sent_cnt++;
	endtask

	function automatic logic [23:0] pack_item(c8x_pkg::opcode_t op, logic [11:0] low,
	                                          logic [7:0] rnd);
		return {rnd, op, low};
	endfunction

	// mostly well-formed instructions with random operands; the rest is raw noise
	function automatic logic [15:0] rand_instr();
		c8x_pkg::opcode_t op;
		logic [3:0]       x, y, n;
		logic [7:0]       kk;
		logic [3:0]       alu_ops [9];
		logic [7:0]       misc_ops [4];
		alu_ops  = '{c8x_pkg::ALU_MOV, c8x_pkg::ALU_OR, c8x_pkg::ALU_AND, c8x_pkg::ALU_XOR,
		             c8x_pkg::ALU_ADD, c8x_pkg::ALU_SUB, c8x_pkg::ALU_SHR, c8x_pkg::ALU_SUBN,
		             c8x_pkg::ALU_SHL};
		misc_ops = '{c8x_pkg::MISC_LD_VX_DT, c8x_pkg::MISC_LD_DT_VX, c8x_pkg::MISC_LD_ST_VX,
		             c8x_pkg::MISC_ADD_I_VX};
		x  = 4'($urandom);
		y  = 4'($urandom);
		n  = 4'($urandom);
		kk = 8'($urandom);
		if ($urandom_range(0, 99) < 10)
			return 16'($urandom);
		case ($urandom_range(0, 11))
			0:  op = c8x_pkg::OP_JP;
			1:  op = c8x_pkg::OP_SE_IMM;
			2:  op = c8x_pkg::OP_SNE_IMM;
			3:  op = c8x_pkg::OP_SE_REG;
			4:  op = c8x_pkg::OP_LD_IMM;
			5:  op = c8x_pkg::OP_ADD_IMM;
			6:  op = c8x_pkg::OP_SNE_REG;
			7:  op = c8x_pkg::OP_LD_I;
			8:  op = c8x_pkg::OP_JP_V0;
			9:  op = c8x_pkg::OP_RND;
			10: op = c8x_pkg::OP_MISC;
			default: op = c8x_pkg::OP_ALU;
		endcase
		case (op)
			// small immediates so compares against register contents hit often
			c8x_pkg::OP_SE_IMM, c8x_pkg::OP_SNE_IMM:
				if ($urandom_range(0, 1)) kk = 8'($urandom_range(0, 2));
			c8x_pkg::OP_SE_REG, c8x_pkg::OP_SNE_REG: begin
				if ($urandom_range(0, 9) != 0) n = 4'h0;
				if ($urandom_range(0, 2) == 0) y = x;
			end
			c8x_pkg::OP_ALU: if ($urandom_range(0, 9) != 0) n = alu_ops[$urandom_range(0, 8)];
			c8x_pkg::OP_MISC:
				if ($urandom_range(0, 9) != 0) kk = misc_ops[$urandom_range(0, 3)];
			default: ;
		endcase
		if (op == c8x_pkg::OP_ALU || op == c8x_pkg::OP_SE_REG || op == c8x_pkg::OP_SNE_REG)
			return {op, x, y, n};
		return {op, x, kk};
	endfunction

	initial begin
		int burst_left;
		int gap;
		logic [23:0] item;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;

		// Directed: register extremes, every ALU op and flag rule, VF as target,
		// skips (including one wrapping the pc), jumps, timers, I, random mask, unsupported words.
		directed_q.push_back(pack_item(c8x_pkg::OP_LD_IMM, 12'h0FF, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_ADD_IMM, 12'h001, 8'hFF));   // wraps V0 to 0
		directed_q.push_back(pack_item(c8x_pkg::OP_LD_IMM, 12'h1FF, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_LD_IMM, 12'h2FF, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_ALU, {8'h12, c8x_pkg::ALU_ADD}, 8'h00));
		// carry out above, borrow next, then equal operands
		directed_q.push_back(pack_item(c8x_pkg::OP_ALU, {8'h12, c8x_pkg::ALU_SUB}, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_ALU, {8'h12, c8x_pkg::ALU_SUBN}, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_ALU, {8'h20, c8x_pkg::ALU_SHR}, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_ALU, {8'h20, c8x_pkg::ALU_SHL}, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_LD_IMM, 12'hF80, 8'h00));
		// flag beats result
		directed_q.push_back(pack_item(c8x_pkg::OP_ALU, {8'hFF, c8x_pkg::ALU_SHL}, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_ALU, {8'h32, c8x_pkg::ALU_MOV}, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_ALU, {8'h31, c8x_pkg::ALU_OR}, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_ALU, {8'h32, c8x_pkg::ALU_AND}, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_ALU, {8'h32, c8x_pkg::ALU_XOR}, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_ALU, 12'h328, 8'h00));  // undefined ALU code
		directed_q.push_back(pack_item(c8x_pkg::OP_ALU, 12'hFFF, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_SE_REG, 12'h330, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_SE_REG, 12'h331, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_SNE_REG, 12'h120, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_SNE_REG, 12'h12F, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_SE_IMM, 12'h100, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_LD_I, 12'hFFF, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_MISC, {4'h2, c8x_pkg::MISC_ADD_I_VX}, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_MISC, {4'h2, c8x_pkg::MISC_LD_DT_VX}, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_MISC, {4'h1, c8x_pkg::MISC_LD_ST_VX}, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_MISC, {4'h5, c8x_pkg::MISC_LD_VX_DT}, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_RND, 12'h5A5, 8'hFF));
		directed_q.push_back(pack_item(c8x_pkg::OP_RND, 12'h6FF, 8'h5A));
		directed_q.push_back(pack_item(c8x_pkg::OP_JP, 12'hFFE, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_SNE_IMM, 12'h0FF, 8'h00));   // taken, pc wraps
		directed_q.push_back(pack_item(c8x_pkg::OP_LD_IMM, 12'h0FF, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_JP_V0, 12'hFFF, 8'h00));     // target wraps
		directed_q.push_back(pack_item(c8x_pkg::OP_SYS, 12'h0E0, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_CALL, 12'hABC, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_DRW, 12'h123, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_SKP, 12'h19E, 8'h00));
		directed_q.push_back(pack_item(c8x_pkg::OP_MISC, 12'h10A, 8'h00));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[k])
			send_instr(directed_q[k][15:0], directed_q[k][23:16]);

		// Random phase in bursts; gaps of zero merge bursts into back-to-back stretches.
		burst_left = 0;
		for (int k = 0; k < N_RANDOM; k++) begin
			if (k == DRAIN_AT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end else if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			item = {8'($urandom), rand_instr()};
			send_instr(item[15:0], item[23:16]);
			burst_left--;
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
